[hw/rtl/mf3_pkg.sv]
// Package for the 3x3 median filter: pixel and coordinate widths, register
// indexes and reset values, and the types shared between the filter modules.
// Depends on nothing.
package mf3_pkg;

   // Field widths of the pixel and result items.
   localparam int PIXEL_W   = 8;
   localparam int COORD_W   = 10;
   localparam int NEIGHBORS = 8;

   // Configuration port.
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [CSR_W-1:0] DIM_RESET = 11'd1024;
   localparam int               DIM_MIN   = 3;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef pixel_type [NEIGHBORS-1:0] neigh_type;

   // Position of one item and what it means for the output.
   typedef struct packed {
      logic               interior;
      logic               last;
      logic [COORD_W-1:0] center_row;
      logic [COORD_W-1:0] center_col;
   } pos_info_type;

endpackage

[hw/rtl/mf3_req_if.sv]
// Input channel of the median filter: valid, ready and one pixel item.
// Depends on mf3_pkg.
interface mf3_req_if;
   import mf3_pkg::*;

   logic              valid;
   logic              ready;
   logic [PIXEL_W-1:0] pixel;
   logic              frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);

endinterface

[hw/rtl/mf3_rsp_if.sv]
// Result channel of the median filter: valid, ready and one filtered item.
// Depends on mf3_pkg.
interface mf3_rsp_if;
   import mf3_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] filtered;
   logic [COORD_W-1:0] center_row;
   logic [COORD_W-1:0] center_col;
   logic               frame_done;

   modport source (output valid, output filtered, output center_row,
                   output center_col, output frame_done, input ready);
   modport sink   (input valid, input filtered, input center_row,
                   input center_col, input frame_done, output ready);

endinterface

[hw/rtl/mf3_ram.sv]
// Generic simple dual-port RAM: one write port and one read port with a
// registered, enabled read. Read during write to the same address returns old data.
// Depends on nothing.
module mf3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while the read is not enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mf3_position.sv]
// Frame geometry registers and raster position counters of the median filter.
// Gives the line store column and the window position of each accepted item.
// Depends on mf3_pkg.
module mf3_position #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [mf3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mf3_pkg::CSR_W-1:0]      csr_wr_data,
   input  logic                           accept,
   input  logic                           frame_start,
   output logic [$clog2(MAX_WIDTH)-1:0]   col,
   output mf3_pkg::pos_info_type          info
);
   import mf3_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int MW  = (CW > RW) ? CW : RW;
   localparam int DW  = (MW + 1 > CSR_W) ? MW + 1 : CSR_W;

   logic [CSR_W-1:0] frame_width_ff;
   logic [CSR_W-1:0] frame_height_ff;
   logic [CW-1:0]    col_ff;
   logic [CW-1:0]    col_in;
   logic [RW-1:0]    row_ff;
   logic [RW-1:0]    row_in;

   logic [DW-1:0] w_eff;
   logic [DW-1:0] h_eff;
   logic [DW-1:0] col_a;
   logic [DW-1:0] row_a;
   logic [DW-1:0] col_b;
   logic [DW-1:0] row_b;
   logic [DW-1:0] row_c;
   logic [DW-1:0] col_inc;
   logic [DW-1:0] row_inc;
   logic [DW-1:0] cr;
   logic [DW-1:0] cc;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_RESET;
         frame_height_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Clamp the frame size to the range the line store supports.
   always_comb begin
      priority if (DW'(frame_width_ff) < DW'(DIM_MIN)) begin
         w_eff = DW'(DIM_MIN);
      end else if (DW'(frame_width_ff) > DW'(MAX_WIDTH)) begin
         w_eff = DW'(MAX_WIDTH);
      end else begin
         w_eff = DW'(frame_width_ff);
      end
      priority if (DW'(frame_height_ff) < DW'(DIM_MIN)) begin
         h_eff = DW'(DIM_MIN);
      end else if (DW'(frame_height_ff) > DW'(MAX_HEIGHT)) begin
         h_eff = DW'(MAX_HEIGHT);
      end else begin
         h_eff = DW'(frame_height_ff);
      end
   end

   // Position of the arriving item: frame start, then wrap of a column or
   // row that lies past a frame that has shrunk.
   always_comb begin
      col_a = frame_start ? '0 : DW'(col_ff);
      row_a = frame_start ? '0 : DW'(row_ff);
      if (col_a >= w_eff) begin
         col_b = '0;
         row_b = row_a + DW'(1);
      end else begin
         col_b = col_a;
         row_b = row_a;
      end
      row_c = (row_b >= h_eff) ? '0 : row_b;
   end

   // Window centre and the last interior pixel of the frame.
   always_comb begin
      cr                 = row_c - DW'(1);
      cc                 = col_b - DW'(1);
      info.interior      = (row_c >= DW'(2)) && (col_b >= DW'(2));
      info.last          = (cr == h_eff - DW'(2)) && (cc == w_eff - DW'(2));
      info.center_row    = cr[COORD_W-1:0];
      info.center_col    = cc[COORD_W-1:0];
      col                = col_b[CW-1:0];
   end

   // Advance one pixel in raster order, wrapping at row and frame end.
   always_comb begin
      col_inc = col_b + DW'(1);
      row_inc = row_c + DW'(1);
      if (col_inc >= w_eff) begin
         col_in = '0;
         row_in = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
      end else begin
         col_in = col_inc[CW-1:0];
         row_in = row_c[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

`ifndef NO_ASSERTIONS
   // A frame start puts the next pixel at column one of row zero.
   a_frame_start_pos: assert property (@(posedge clock) disable iff (reset)
      accept && frame_start |=> col_ff == CW'(1) && row_ff == RW'(0))
      else $error("position after frame start is wrong");

   // An interior result never reports a centre on the first row or column.
   a_interior_center: assert property (@(posedge clock) disable iff (reset)
      info.interior |-> cr != '0 && cc != '0)
      else $error("interior item with border centre");
`endif

endmodule

[hw/rtl/mf3_median.sv]
// Median of the eight neighbours of a window: a Batcher odd-even merge sort
// network, then the truncated mean of the two middle values.
// Depends on mf3_pkg.
module mf3_median (
   input  mf3_pkg::neigh_type  vals,
   output mf3_pkg::pixel_type  mean
);
   import mf3_pkg::*;

   localparam int NUM_CMP = 19;
   localparam int LO_IDX [NUM_CMP] = '{0, 2, 4, 6, 0, 1, 4, 5, 1, 5,
                                       0, 1, 2, 3, 2, 3, 1, 3, 5};
   localparam int HI_IDX [NUM_CMP] = '{1, 3, 5, 7, 2, 3, 6, 7, 2, 6,
                                       4, 5, 6, 7, 4, 5, 2, 4, 6};

   pixel_type        v [NEIGHBORS];
   logic [PIXEL_W:0] sum;

   // Compare-exchange network, six layers deep; v ends up ascending.
   always_comb begin
      pixel_type t;
      t = '0;
      for (int i = 0; i < NEIGHBORS; i++) begin
         v[i] = vals[i];
      end
      for (int k = 0; k < NUM_CMP; k++) begin
         if (v[LO_IDX[k]] > v[HI_IDX[k]]) begin
            t              = v[LO_IDX[k]];
            v[LO_IDX[k]]   = v[HI_IDX[k]];
            v[HI_IDX[k]]   = t;
         end
      end
   end

   // Mean of the fourth and fifth smallest, truncated.
   assign sum  = {1'b0, v[3]} + {1'b0, v[4]};
   assign mean = sum[PIXEL_W:1];

endmodule

[hw/rtl/median_filter_3x3_ring.sv]
// 3x3 median filter over a raster-order pixel stream; top level.
// A result passes the window stage register and then the output register.
// Throughput: one pixel per cycle unless stalled, set by the one line store RAM port pair.
// Border pixels give no result; an interior result that waits does not stop border pixels.
// Reset: position to row 0, column 0, frame size to 1024 x 1024, no result pending.
// The line store is not cleared; it is always written before an interior read.
module median_filter_3x3_ring #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [mf3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mf3_pkg::CSR_W-1:0]     csr_wr_data,
   mf3_req_if.sink                       req_ch,
   mf3_rsp_if.source                     rsp_ch
);
   import mf3_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   // Position stage outputs.
   logic [AW-1:0] req_col;
   pos_info_type  req_info;
   logic          req_accept;

   // Window stage registers.
   logic          s1_valid_ff;
   logic          s1_valid_in;
   pixel_type     s1_pixel_ff;
   pos_info_type  s1_info_ff;
   logic [AW-1:0] s1_col_ff;
   logic          fwd_ff;
   logic          fwd_in;
   pixel_type     fwd_top_ff;
   pixel_type     fwd_mid_ff;
   pixel_type     win_ff [6];

   // Output register.
   logic          out_valid_ff;
   logic          out_valid_in;
   pixel_type     out_filtered_ff;
   logic [COORD_W-1:0] out_row_ff;
   logic [COORD_W-1:0] out_col_ff;
   logic          out_done_ff;

   logic                   out_free;
   logic                   s1_move;
   logic                   s1_adv;
   logic                   out_load;
   logic [2*PIXEL_W-1:0]   ram_rd_data;
   logic [2*PIXEL_W-1:0]   ram_wr_data;
   pixel_type              top;
   pixel_type              mid;
   neigh_type              neigh;
   pixel_type              median;

   // Pipeline flow: the window stage moves on unless its result finds the
   // output register full.
   assign out_free   = !out_valid_ff || rsp_ch.ready;
   assign s1_move    = s1_valid_ff && (!s1_info_ff.interior || out_free);
   assign s1_adv     = !s1_valid_ff || s1_move;
   assign req_ch.ready = s1_adv;
   assign req_accept = req_ch.valid && s1_adv;
   assign out_load   = s1_valid_ff && s1_info_ff.interior && out_free;

   mf3_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .accept      (req_accept),
      .frame_start (req_ch.frame_start),
      .col         (req_col),
      .info        (req_info)
   );

   // Both line stores share one RAM: upper row in the high byte, middle row
   // in the low byte.
   assign ram_wr_data = {mid, s1_pixel_ff};

   mf3_ram #(
      .WIDTH (2*PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (s1_adv),
      .rd_addr (req_col),
      .rd_data (ram_rd_data)
   );

   // A read that collides with the write of the item ahead takes the
   // written values instead of the old RAM data.
   assign fwd_in = req_accept && s1_move && (req_col == s1_col_ff);
   assign top    = fwd_ff ? fwd_top_ff : ram_rd_data[2*PIXEL_W-1:PIXEL_W];
   assign mid    = fwd_ff ? fwd_mid_ff : ram_rd_data[PIXEL_W-1:0];

   assign s1_valid_in = s1_adv ? req_accept : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_adv) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_pixel_ff <= req_ch.pixel;
         s1_info_ff  <= req_info;
         s1_col_ff   <= req_col;
         fwd_top_ff  <= mid;
         fwd_mid_ff  <= s1_pixel_ff;
      end
   end

   // Window shift: the previous column moves back and the current column
   // comes in from the line store and the pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_move) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= s1_pixel_ff;
      end
   end

   // Eight neighbours; the centre of the window is left out.
   always_comb begin
      neigh[0] = win_ff[0];
      neigh[1] = win_ff[1];
      neigh[2] = win_ff[2];
      neigh[3] = win_ff[3];
      neigh[4] = win_ff[5];
      neigh[5] = top;
      neigh[6] = mid;
      neigh[7] = s1_pixel_ff;
   end

   mf3_median u_median (
      .vals (neigh),
      .mean (median)
   );

   // Output register.
   assign out_valid_in = out_free ? out_load : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_filtered_ff <= median;
         out_row_ff      <= s1_info_ff.center_row;
         out_col_ff      <= s1_info_ff.center_col;
         out_done_ff     <= s1_info_ff.last;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.filtered   = out_filtered_ff;
   assign rsp_ch.center_row = out_row_ff;
   assign rsp_ch.center_col = out_col_ff;
   assign rsp_ch.frame_done = out_done_ff;

`ifndef NO_ASSERTIONS
   // Input backpressure comes only from an interior item blocked by a full,
   // stalled output register.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> s1_valid_ff && s1_info_ff.interior && out_valid_ff
                        && !rsp_ch.ready)
      else $error("input stalled without a blocked result");

   // Forwarding is only ever armed for an item held in the window stage.
   a_fwd_valid: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_valid_ff)
      else $error("line store forward without an item");

   // A blocked window stage keeps its item and its column.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_col_ff)
                                  && $stable(s1_pixel_ff))
      else $error("window stage item lost while blocked");
`endif

endmodule
